### design/lzns_pkg.sv
// ----------------------------------------------------------------------------
// lzns_pkg
// Shared types and constants for the lane zone nearest object selector.
// ----------------------------------------------------------------------------
package lzns_pkg;

    // positions are 1/16 m, a lane is 4 m wide, lane edge band is 0.75 m
    localparam int POS_FRAC_BITS = 4;
    localparam int S_BITS        = 17;
    localparam int D_BITS        = 8;
    localparam int LANE_SHIFT    = POS_FRAC_BITS + 2;
    localparam int LANE_BITS     = D_BITS - LANE_SHIFT;
    localparam int LANE_W        = 1 << LANE_SHIFT;
    localparam int EDGE_W        = (3 << POS_FRAC_BITS) >> 2;

    localparam int ZONES         = 6;
    localparam int BEHIND_BASE   = 3;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int RANGE_BITS    = 13;
    localparam int MARGIN_BITS   = 12;
    localparam int RLANE_BITS    = 2;

    localparam logic [RANGE_BITS-1:0]  RST_MAX_FRONT   = 13'd800;
    localparam logic [RANGE_BITS-1:0]  RST_MAX_REAR    = 13'd480;
    localparam logic [MARGIN_BITS-1:0] RST_BLIND_FRONT = 12'd160;
    localparam logic [MARGIN_BITS-1:0] RST_BLIND_REAR  = 12'd160;
    localparam logic [RLANE_BITS-1:0]  RST_RIGHTMOST   = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_FRONT   = 3'd0,
        CFG_MAX_REAR    = 3'd1,
        CFG_BLIND_FRONT = 3'd2,
        CFG_BLIND_REAR  = 3'd3,
        CFG_RIGHTMOST   = 3'd4
    } t_cfg_idx;

    // classified beat passed from front to back
    typedef struct packed {
        logic [ZONES-1:0]  offer;    // zone 0..2 ahead (ego,left,right), 3..5 behind
        logic              blind_l;
        logic              blind_r;
        logic              has_l;
        logic              has_r;
        logic              last;
        logic [S_BITS-1:0] s;
    } t_cls;

    typedef struct packed {
        logic pop;
        logic last;
    } t_back_stat;

endpackage

### design/lzns_fifo.sv
// ----------------------------------------------------------------------------
// lzns_fifo
// Small register queue decoupling the classifier from the zone tracker.
// ----------------------------------------------------------------------------
module lzns_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_rdata = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_wr && !o_full) r_wp <= r_wp + 1'b1;
            if (i_rd && !o_empty) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) r_mem[r_wp[AW-1:0]] <= i_wdata;
    end

endmodule

### design/lzns_front.sv
// ----------------------------------------------------------------------------
// lzns_front
// Config registers plus range, zone and lane classification of each beat.
// ----------------------------------------------------------------------------
module lzns_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lzns_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [lzns_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                              i_tracked,
    input  logic [lzns_pkg::S_BITS-1:0]       i_obj_s,
    input  logic [lzns_pkg::D_BITS-1:0]       i_obj_d,
    input  logic [lzns_pkg::S_BITS-1:0]       i_ego_s,
    input  logic [lzns_pkg::D_BITS-1:0]       i_ego_d,
    input  logic                              i_last,
    output lzns_pkg::t_cls                    o_cls
);
    import lzns_pkg::*;

    localparam int LW = LANE_BITS + 2;
    localparam int SW = S_BITS + 1;

    logic [RANGE_BITS-1:0]  r_max_front;
    logic [RANGE_BITS-1:0]  r_max_rear;
    logic [MARGIN_BITS-1:0] r_blind_front;
    logic [MARGIN_BITS-1:0] r_blind_rear;
    logic [RLANE_BITS-1:0]  r_rightmost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_front   <= RST_MAX_FRONT;
            r_max_rear    <= RST_MAX_REAR;
            r_blind_front <= RST_BLIND_FRONT;
            r_blind_rear  <= RST_BLIND_REAR;
            r_rightmost   <= RST_RIGHTMOST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_FRONT:   r_max_front   <= i_cfg_wdata[RANGE_BITS-1:0];
                CFG_MAX_REAR:    r_max_rear    <= i_cfg_wdata[RANGE_BITS-1:0];
                CFG_BLIND_FRONT: r_blind_front <= i_cfg_wdata[MARGIN_BITS-1:0];
                CFG_BLIND_REAR:  r_blind_rear  <= i_cfg_wdata[MARGIN_BITS-1:0];
                CFG_RIGHTMOST:   r_rightmost   <= i_cfg_wdata[RLANE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0]         w_obj, w_ego;
    logic                  w_in_range, w_ahead, w_behind, w_zoned, w_blind;
    logic [LW-1:0]         w_ol, w_el, w_rl;
    logic [LANE_SHIFT-1:0] w_frac;
    logic                  w_le, w_re, w_in_ego, w_in_left, w_in_right;
    logic                  w_off_l, w_off_r;

    always_comb begin
        w_obj = SW'(i_obj_s);
        w_ego = SW'(i_ego_s);
        // lower bounds are compared as obj + margin < ego so nothing goes negative
        w_in_range = i_tracked &&
                     !(w_obj > w_ego + SW'(r_max_front)) &&
                     !(w_obj + SW'(r_max_rear) < w_ego);
        w_ahead  = w_obj > w_ego + SW'(r_blind_front);
        w_behind = !w_ahead && (w_obj + SW'(r_blind_rear) < w_ego);
        w_zoned  = w_ahead || w_behind;

        w_ol   = LW'(i_obj_d[D_BITS-1:LANE_SHIFT]);
        w_el   = LW'(i_ego_d[D_BITS-1:LANE_SHIFT]);
        w_rl   = LW'(r_rightmost);
        w_frac = i_obj_d[LANE_SHIFT-1:0];
        w_le   = w_frac < LANE_SHIFT'(EDGE_W);
        w_re   = w_frac > LANE_SHIFT'(LANE_W - EDGE_W);

        w_in_ego   = (w_ol == w_el) || (w_le && w_ol == w_el + 1'b1) ||
                     (w_re && w_ol + 1'b1 == w_el);
        w_in_left  = (w_ol + 1'b1 == w_el) || (w_le && w_ol == w_el) ||
                     (w_re && w_ol + LW'(2) == w_el);
        w_in_right = (w_ol == w_el + 1'b1) || (w_le && w_ol == w_el + LW'(2)) ||
                     (w_re && w_ol == w_el);

        o_cls.has_l = (w_el != '0);
        o_cls.has_r = (w_el != w_rl);
        w_off_l = w_in_range && o_cls.has_l && w_in_left;
        w_off_r = w_in_range && o_cls.has_r && w_in_right;
        w_blind = !w_zoned;

        o_cls.offer = '0;
        o_cls.offer[0] = w_ahead && w_in_range && w_in_ego;
        o_cls.offer[1] = w_ahead && w_off_l;
        o_cls.offer[2] = w_ahead && w_off_r;
        o_cls.offer[BEHIND_BASE]     = w_behind && w_in_range && w_in_ego;
        o_cls.offer[BEHIND_BASE + 1] = w_behind && w_off_l;
        o_cls.offer[BEHIND_BASE + 2] = w_behind && w_off_r;
        o_cls.blind_l = w_blind && w_off_l;
        o_cls.blind_r = w_blind && w_off_r;
        o_cls.last    = i_last;
        o_cls.s       = i_obj_s;
    end

endmodule

### design/lzns_back.sv
// ----------------------------------------------------------------------------
// lzns_back
// Running nearest-per-zone tracker, blind flags and registered result beat.
// ----------------------------------------------------------------------------
module lzns_back #(
    parameter int ID_BITS = 8,
    parameter int OUT_W   = 56
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [ID_BITS-1:0]   i_id,
    input  lzns_pkg::t_cls       i_cls,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [OUT_W-1:0]     o_m_tdata,
    output lzns_pkg::t_back_stat o_stat
);
    import lzns_pkg::*;

    localparam int IDW   = ID_BITS + 1;
    localparam int RAW_W = ZONES * IDW + 2;

    logic [IDW-1:0]    r_id [ZONES];
    logic [S_BITS-1:0] r_s  [ZONES];
    logic              r_bl, r_br;
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;

    logic [IDW-1:0]    n_id [ZONES];
    logic [ZONES-1:0]  w_take;
    logic [RAW_W-1:0]  w_raw;
    logic              w_pop;

    // a result may only leave when the output register is free or draining
    assign w_pop = i_valid && (!i_cls.last || !r_m_valid || i_m_tready);

    always_comb begin
        for (int z = 0; z < ZONES; z++) begin
            // empty slot takes anything; otherwise strictly nearer only
            w_take[z] = i_cls.offer[z] && (r_id[z][IDW-1] ||
                        ((z < BEHIND_BASE) ? (i_cls.s < r_s[z]) : (i_cls.s > r_s[z])));
            n_id[z]   = w_take[z] ? {1'b0, i_id} : r_id[z];
            w_raw[z*IDW +: IDW] = n_id[z];
        end
        w_raw[ZONES*IDW]     = r_bl | i_cls.blind_l | !i_cls.has_l;
        w_raw[ZONES*IDW + 1] = r_br | i_cls.blind_r | !i_cls.has_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < ZONES; z++) r_id[z] <= '1;
            r_bl      <= 1'b0;
            r_br      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_cls.last) begin
                    for (int z = 0; z < ZONES; z++) r_id[z] <= '1;
                    r_bl <= 1'b0;
                    r_br <= 1'b0;
                end else begin
                    for (int z = 0; z < ZONES; z++) r_id[z] <= n_id[z];
                    r_bl <= r_bl | i_cls.blind_l;
                    r_br <= r_br | i_cls.blind_r;
                end
            end
            if (w_pop && i_cls.last) r_m_valid <= 1'b1;
            else if (i_m_tready)     r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int z = 0; z < ZONES; z++) begin
            if (w_pop && w_take[z]) r_s[z] <= i_cls.s;
        end
        if (w_pop && i_cls.last) r_m_data <= OUT_W'(w_raw);
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_stat.pop  = w_pop;
    assign o_stat.last = i_cls.last;

endmodule

### design/lane_zone_nearest_object_select.sv
// ----------------------------------------------------------------------------
// lane_zone_nearest_object_select
// Nearest object ahead/behind in ego, left and right lanes, plus blind spots.
// ----------------------------------------------------------------------------
// Throughput: one object beat per cycle while the queue has room; the zone
//   tracker updates all six bests at once, so only a stalled result holds up the queue.
// Path: a last beat accepted on the stream is written to the 4-entry queue,
//   retired from its head into the output register, and taken from there.
// Reset: synchronous, active low; clears the queue, bests, blind flags and
//   output valid, and loads the range and margin registers with their defaults.
module lane_zone_nearest_object_select #(
    parameter int ID_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lzns_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lzns_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // object_id, object_s, object_d, ego_s, ego_d, zero fill
    input  logic [((ID_BITS + 2*lzns_pkg::S_BITS + 2*lzns_pkg::D_BITS + 7) / 8) * 8 - 1:0]
                                               i_s_tdata,
    // object_tracked
    input  logic                               i_s_tuser,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // ahead_id, ahead_left_id, ahead_right_id, behind_id, behind_left_id,
    // behind_right_id, left_blind_busy, right_blind_busy, zero fill
    output logic [((lzns_pkg::ZONES * (ID_BITS + 1) + 2 + 7) / 8) * 8 - 1:0]
                                               o_m_tdata
);
    import lzns_pkg::*;

    localparam int OUT_W  = ((ZONES * (ID_BITS + 1) + 2 + 7) / 8) * 8;
    localparam int OS_LO  = ID_BITS;
    localparam int OD_LO  = OS_LO + S_BITS;
    localparam int ES_LO  = OD_LO + D_BITS;
    localparam int ED_LO  = ES_LO + S_BITS;
    localparam int CLS_W  = $bits(t_cls);
    localparam int Q_W    = ID_BITS + CLS_W;

    t_cls             w_cls, w_q_cls;
    t_back_stat       w_stat;
    logic [Q_W-1:0]   w_q_rdata;
    logic [ID_BITS-1:0] w_q_id;
    logic             w_q_full, w_q_empty;

    lzns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tracked   (i_s_tuser),
        .i_obj_s     (i_s_tdata[OS_LO +: S_BITS]),
        .i_obj_d     (i_s_tdata[OD_LO +: D_BITS]),
        .i_ego_s     (i_s_tdata[ES_LO +: S_BITS]),
        .i_ego_d     (i_s_tdata[ED_LO +: D_BITS]),
        .i_last      (i_s_tlast),
        .o_cls       (w_cls)
    );

    lzns_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_s_tvalid),
        .i_wdata ({i_s_tdata[ID_BITS-1:0], w_cls}),
        .o_full  (w_q_full),
        .i_rd    (w_stat.pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    assign o_s_tready = !w_q_full;
    assign w_q_cls    = w_q_rdata[CLS_W-1:0];
    assign w_q_id     = w_q_rdata[Q_W-1:CLS_W];

    lzns_back #(
        .ID_BITS (ID_BITS),
        .OUT_W   (OUT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_q_empty),
        .i_id       (w_q_id),
        .i_cls      (w_q_cls),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_stat     (w_stat)
    );

    // a result beat only appears after the tracker retired a last beat
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_stat.pop && w_stat.last))
        else $error("result beat without a retired last beat");

    // retiring a last beat always leaves a pending result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.pop && w_stat.last) |=> o_m_tvalid)
        else $error("last beat retired but no result pending");

    // tracker never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pop |-> !w_q_empty)
        else $error("tracker popped an empty queue");

    // nothing is presented straight after reset
    a_reset_clears: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid set coming out of reset");

endmodule

### test/lane_zone_nearest_object_select_check.sv
// ----------------------------------------------------------------------------
// lane_zone_nearest_object_select_check
// Watches the configuration port and both streams of the lane zone selector.
// It tracks the six nearest-object bests and the blind-spot flags of each
// scene, queues one expected summary per last object beat, and compares each
// result beat with the oldest queued summary, field by field.
// ----------------------------------------------------------------------------
module lane_zone_nearest_object_select_check #(
    parameter int ID_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lzns_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lzns_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    // object_id, object_s, object_d, ego_s, ego_d, zero fill
    input  logic [((ID_BITS + 2*lzns_pkg::S_BITS + 2*lzns_pkg::D_BITS + 7) / 8) * 8 - 1:0]
                                                 i_s_tdata,
    // object_tracked
    input  logic                                 i_s_tuser,
    input  logic                                 i_s_tlast,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    // ahead_id, ahead_left_id, ahead_right_id, behind_id, behind_left_id,
    // behind_right_id, left_blind_busy, right_blind_busy, zero fill
    input  logic [((lzns_pkg::ZONES * (ID_BITS + 1) + 2 + 7) / 8) * 8 - 1:0]
                                                 i_m_tdata,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    import lzns_pkg::*;

    localparam int S_TW       = ((ID_BITS + 2*S_BITS + 2*D_BITS + 7) / 8) * 8;
    localparam int M_TW       = ((ZONES * (ID_BITS + 1) + 2 + 7) / 8) * 8;
    localparam int FRAC       = 4;
    localparam int LANE_UNITS = 4 << FRAC;
    localparam int EDGE_UNITS = (3 << FRAC) >> 2;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [ZONES-1:0][ID_BITS:0] ids;
        logic                        left_busy;
        logic                        right_busy;
    } t_summary;

    // running bests of the scene: 0..2 ahead (ego, left, right), 3..5 behind
    int       near_id [ZONES];
    int       near_s  [ZONES];
    bit       blind_l;
    bit       blind_r;

    int       front_range;
    int       rear_range;
    int       blind_front;
    int       blind_rear;
    int       right_lane;

    t_summary summary_q [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS)
            $display("ERROR: %s", msg);
        o_fail_count++;
    endtask

    task automatic clear_scene();
        int z;
        for (z = 0; z < ZONES; z++) begin
            near_id[z] = -1;
            near_s[z]  = 0;
        end
        blind_l = 1'b0;
        blind_r = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        unique case (idx)
            CFG_MAX_FRONT:   front_range = val[RANGE_BITS-1:0];
            CFG_MAX_REAR:    rear_range  = val[RANGE_BITS-1:0];
            CFG_BLIND_FRONT: blind_front = val[MARGIN_BITS-1:0];
            CFG_BLIND_REAR:  blind_rear  = val[MARGIN_BITS-1:0];
            CFG_RIGHTMOST:   right_lane  = val[RLANE_BITS-1:0];
            default: ;
        endcase
    endtask

    // strictly nearer replaces, so the first of equals is kept
    task automatic offer_zone(input int z, input bit ahead, input int id, input int s);
        if (near_id[z] < 0 || (ahead ? (s < near_s[z]) : (s > near_s[z]))) begin
            near_id[z] = id;
            near_s[z]  = s;
        end
    endtask

    task automatic take_object(input logic [S_TW-1:0] beat, input logic tracked,
                               input logic last);
        int       id, os, od, es, ed;
        int       own_lane, lane, frac, base, z;
        bit       has_l, has_r, lft_edge, rgt_edge, in_e, in_l, in_r, ahead;
        t_summary res;
        id = beat[ID_BITS-1:0];
        os = beat[ID_BITS +: S_BITS];
        od = beat[ID_BITS + S_BITS +: D_BITS];
        es = beat[ID_BITS + S_BITS + D_BITS +: S_BITS];
        ed = beat[ID_BITS + 2*S_BITS + D_BITS +: D_BITS];

        own_lane = ed / LANE_UNITS;
        has_l    = own_lane != 0;
        has_r    = own_lane != right_lane;

        if (tracked && !(os > es + front_range) && !(os < es - rear_range)) begin
            lane     = od / LANE_UNITS;
            frac     = od - lane * LANE_UNITS;
            lft_edge = frac < EDGE_UNITS;
            rgt_edge = frac > LANE_UNITS - EDGE_UNITS;
            in_e = lane == own_lane || (lft_edge && lane - 1 == own_lane) ||
                   (rgt_edge && lane + 1 == own_lane);
            in_l = lane == own_lane - 1 || (lft_edge && lane - 1 == own_lane - 1) ||
                   (rgt_edge && lane + 1 == own_lane - 1);
            in_r = lane == own_lane + 1 || (lft_edge && lane - 1 == own_lane + 1) ||
                   (rgt_edge && lane + 1 == own_lane + 1);
            base  = -1;
            ahead = 1'b0;
            if (os > es + blind_front) begin
                base  = 0;
                ahead = 1'b1;
            end else if (os < es - blind_rear) begin
                base = BEHIND_BASE;
            end
            if (base >= 0) begin
                if (has_l && in_l)
                    offer_zone(base + 1, ahead, id, os);
                if (has_r && in_r)
                    offer_zone(base + 2, ahead, id, os);
                if (in_e)
                    offer_zone(base, ahead, id, os);
            end else begin
                if (has_l && in_l)
                    blind_l = 1'b1;
                if (has_r && in_r)
                    blind_r = 1'b1;
            end
        end

        if (last) begin
            for (z = 0; z < ZONES; z++)
                res.ids[z] = (ID_BITS + 1)'(near_id[z]);
            res.left_busy  = blind_l || !has_l;
            res.right_busy = blind_r || !has_r;
            summary_q = {summary_q, res};
            clear_scene();
        end
    endtask

    function automatic string zone_label(input int z);
        unique case (z)
            0:       return "ahead_id";
            1:       return "ahead_left_id";
            2:       return "ahead_right_id";
            3:       return "behind_id";
            4:       return "behind_left_id";
            default: return "behind_right_id";
        endcase
    endfunction

    task automatic check_summary(input logic [M_TW-1:0] beat);
        t_summary         want;
        logic [ID_BITS:0] got_id;
        logic             got_l, got_r;
        int               z;
        if (summary_q.size() == 0) begin
            report_mismatch("result beat with no summary pending");
            return;
        end
        want = summary_q.pop_front();
        for (z = 0; z < ZONES; z++) begin
            got_id = beat[z*(ID_BITS+1) +: ID_BITS+1];
            if (got_id !== want.ids[z])
                report_mismatch($sformatf("%s got %0d expected %0d", zone_label(z),
                                          $signed(got_id), $signed(want.ids[z])));
        end
        got_l = beat[ZONES*(ID_BITS+1)];
        got_r = beat[ZONES*(ID_BITS+1) + 1];
        if (got_l !== want.left_busy)
            report_mismatch($sformatf("left_blind_busy got %b expected %b",
                                      got_l, want.left_busy));
        if (got_r !== want.right_busy)
            report_mismatch($sformatf("right_blind_busy got %b expected %b",
                                      got_r, want.right_busy));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scene();
            front_range = 800;
            rear_range  = 480;
            blind_front = 160;
            blind_rear  = 160;
            right_lane  = 2;
            summary_q.delete();
        end else begin
            if (i_cfg_we)
                write_register(i_cfg_idx, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready)
                take_object(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_summary(i_m_tdata);
        end
        o_pending = summary_q.size();
    end

endmodule

### test/lane_zone_nearest_object_select_tb.sv
// ----------------------------------------------------------------------------
// lane_zone_nearest_object_select_tb
// Drives object beats and configuration writes into the lane zone selector.
// A short directed set covers range and zone borders, lane edge bands, ties,
// edge lanes and untracked last beats; random scenes follow under a series
// of register settings, with idle bursts on both streams and one long result
// stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module lane_zone_nearest_object_select_tb;

    import lzns_pkg::*;

    localparam int ID_BITS    = 8;
    localparam int S_TW       = ((ID_BITS + 2*S_BITS + 2*D_BITS + 7) / 8) * 8;
    localparam int M_TW       = ((ZONES * (ID_BITS + 1) + 2 + 7) / 8) * 8;
    localparam int S_MAX      = (1 << S_BITS) - 1;
    localparam int D_MAX      = (1 << D_BITS) - 1;
    localparam int N_OBJECTS  = 1950;
    localparam int CALM_AFTER = 1650;
    localparam int PHASE_LEN  = 220;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 8;

    typedef struct {
        logic [ID_BITS-1:0] id;
        logic               tracked;
        logic [S_BITS-1:0]  os;
        logic [D_BITS-1:0]  od;
        logic [S_BITS-1:0]  es;
        logic [D_BITS-1:0]  ed;
        logic               last;
    } t_object;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_TW-1:0]          s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TW-1:0]          m_tdata;
    int                       fail_count;
    int                       pending;

    int objects_sent = 0;
    bit calm         = 1'b0;
    bit held_off     = 1'b0;
    int cur_front    = 800;
    int cur_rear     = 480;
    int cur_bfront   = 160;
    int cur_brear    = 160;

    lane_zone_nearest_object_select #(.ID_BITS(ID_BITS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    lane_zone_nearest_object_select_check #(.ID_BITS(ID_BITS)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic t_object mk(input int id, input bit tr, input int os, input int od,
                                   input int es, input int ed, input bit last);
        t_object o;
        o.id      = id;
        o.tracked = tr;
        o.os      = os;
        o.od      = od;
        o.es      = es;
        o.ed      = ed;
        o.last    = last;
        return o;
    endfunction

    task automatic send_object(input t_object o);
        logic [S_TW-1:0] beat;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        beat = '0;
        beat[ID_BITS-1:0]                          = o.id;
        beat[ID_BITS +: S_BITS]                    = o.os;
        beat[ID_BITS + S_BITS +: D_BITS]           = o.od;
        beat[ID_BITS + S_BITS + D_BITS +: S_BITS]  = o.es;
        beat[ID_BITS + 2*S_BITS + D_BITS +: D_BITS] = o.ed;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= o.tracked;
        s_tlast  <= o.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        objects_sent++;
    endtask

    // all summaries back, then let the pipeline drain before touching registers
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input int front, input int rear, input int bfront,
                              input int brear, input int rlane);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_MAX_FRONT;
        cfg_wdata <= CFG_DATA_BITS'(front);
        @(posedge clk);
        cfg_idx   <= CFG_MAX_REAR;
        cfg_wdata <= CFG_DATA_BITS'(rear);
        @(posedge clk);
        cfg_idx   <= CFG_BLIND_FRONT;
        cfg_wdata <= CFG_DATA_BITS'(bfront);
        @(posedge clk);
        cfg_idx   <= CFG_BLIND_REAR;
        cfg_wdata <= CFG_DATA_BITS'(brear);
        @(posedge clk);
        cfg_idx   <= CFG_RIGHTMOST;
        cfg_wdata <= CFG_DATA_BITS'(rlane);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_front  = front;
        cur_rear   = rear;
        cur_bfront = bfront;
        cur_brear  = brear;
    endtask

    // one scene: ascending ids around a shared ego, or noise with stray ids/egos
    task automatic run_scene();
        t_object o;
        bit      noisy;
        int      n, k, es, ed, id, prev_s, v;
        noisy = $urandom_range(0, 4) == 0;
        n     = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0:       es = $urandom_range(0, 50);
            1:       es = S_MAX - $urandom_range(0, 50);
            default: es = $urandom_range(0, S_MAX);
        endcase
        ed     = $urandom_range(0, D_MAX);
        id     = $urandom_range(0, 64);
        prev_s = es;
        for (k = 0; k < n; k++) begin
            o.id = noisy ? $urandom_range(0, 255) : id;
            id   = clamp(id + $urandom_range(1, 3), 0, 255);
            o.tracked = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 3) == 0)
                o.od = $urandom_range(0, D_MAX);
            else
                o.od = clamp(ed + int'($urandom_range(0, 160)) - 80, 0, D_MAX);
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, S_MAX);
                1:       v = prev_s;
                2:       v = es + cur_front + int'($urandom_range(0, 2)) - 1;
                3:       v = es - cur_rear + int'($urandom_range(0, 2)) - 1;
                4:       v = es + cur_bfront + int'($urandom_range(0, 2)) - 1;
                5:       v = es - cur_brear + int'($urandom_range(0, 2)) - 1;
                default: v = es - cur_rear - 40 +
                             int'($urandom_range(0, cur_rear + cur_front + 80));
            endcase
            o.os   = clamp(v, 0, S_MAX);
            prev_s = o.os;
            o.es   = es;
            o.ed   = ed;
            if (noisy && $urandom_range(0, 2) == 0) begin
                o.es = clamp(es + int'($urandom_range(0, 200)) - 100, 0, S_MAX);
                o.ed = $urandom_range(0, D_MAX);
            end
            o.last = k == n - 1;
            send_object(o);
        end
    endtask

    // result side: random stalls, plus one long hold-off so the queue backs up
    initial begin
        @(posedge clk);
        forever begin
            if (!held_off && objects_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int phase_mark;
        int front, rear, bfront, brear;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: ego in lane 1, both side lanes present
        send_object(mk(3,   1, 5200, 100, 5000, 96, 0));
        send_object(mk(4,   1, 5200,  90, 5000, 96, 0));   // tie, first kept
        send_object(mk(5,   1, 5800,  20, 5000, 96, 0));   // front range border
        send_object(mk(6,   1, 5801,  96, 5000, 96, 0));   // just out of range
        send_object(mk(7,   1, 4520, 140, 5000, 96, 0));   // rear range border
        send_object(mk(8,   1, 4519,  96, 5000, 96, 0));
        send_object(mk(9,   1, 5000,  10, 5000, 96, 0));   // level, left lane
        send_object(mk(10,  1, 5161, 139, 5000, 96, 0));   // left edge band of lane 2
        send_object(mk(11,  1, 5160, 124, 5000, 96, 0));   // right edge band, blind
        send_object(mk(12,  1, 4839,  53, 5000, 96, 0));
        send_object(mk(13,  0, 5100,  96, 5000, 96, 1));   // untracked last
        // ego in lane 0: no left lane
        send_object(mk(0,   1,     0,   0,      0,   0, 0));
        send_object(mk(1,   1, S_MAX, D_MAX,    0,   0, 0));
        send_object(mk(255, 1,   200,  63,      0,   0, 1));
        // ego in the rightmost lane
        send_object(mk(20,  1, S_MAX, 200, S_MAX, 150, 0));
        send_object(mk(21,  1, 130600, 100, S_MAX, 150, 0));
        send_object(mk(22,  0,     0, D_MAX, S_MAX, 150, 1));
        // ego beyond the rightmost lane
        send_object(mk(30,  1, 65836, D_MAX, 65536, D_MAX, 0));
        send_object(mk(31,  1, 65544, 192, 65536, D_MAX, 0));
        send_object(mk(32,  1, 65536,   0, 65536, D_MAX, 1));
        send_object(mk(40,  0,  1000,  50,  1000,  50, 1));

        wait_quiet();
        set_config(8191, 8191, 4095, 4095, 3);
        phase_mark = objects_sent;
        while (objects_sent < N_OBJECTS) begin
            if (objects_sent - phase_mark >= PHASE_LEN) begin
                wait_quiet();
                if (phase_mark < 2 * PHASE_LEN) begin
                    set_config(0, 0, 0, 0, 0);
                end else begin
                    front  = $urandom_range(0, 1) ? $urandom_range(0, 1500)
                                                  : $urandom_range(0, 8191);
                    rear   = $urandom_range(0, 1) ? $urandom_range(0, 1500)
                                                  : $urandom_range(0, 8191);
                    bfront = $urandom_range(0, 1) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 4095);
                    brear  = $urandom_range(0, 1) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 4095);
                    set_config(front, rear, bfront, brear, $urandom_range(0, 3));
                end
                phase_mark = objects_sent;
            end
            if (objects_sent >= CALM_AFTER)
                calm = 1'b1;
            run_scene();
        end

        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("lane_zone_nearest_object_select_tb passed");
        else
            $display("lane_zone_nearest_object_select_tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("lane_zone_nearest_object_select_tb failed");
        $finish;
    end

endmodule
